/* sv/periodic_timer_table_macros.svh */
// ----------------------------------------------------------------------------
// Periodic timer table assertion macros
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("periodic_timer_table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("periodic_timer_table assertion failed");

`else

`define PTT_ASSERT_IMPL(lbl, ante, cons)
`define PTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer table package
// Sizes, field codes and the microcode program of the timer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int PERIOD_BITS = 16;
    localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // Fixed request and result field widths.
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int ID_W     = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_START  = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_TICK   = 2'd2
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_EXPIRY = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_ZERO_PERIOD = 2'd1,
        STAT_FULL        = 2'd2
    } status_t;

    // Microcode addresses.
    typedef enum logic [2:0] {
        UPC_IDLE,
        UPC_START,
        UPC_SCAN,
        UPC_FULL,
        UPC_DELETE,
        UPC_TICK,
        UPC_DONE
    } upc_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_ZERO_PERIOD,
        COND_SLOT_FREE,
        COND_FIRE
    } cond_t;

    typedef enum logic [1:0] {
        ID_ZERO,
        ID_SLOT,
        ID_REQ
    } id_sel_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ALLOC,
        OP_RELEASE,
        OP_ADVANCE
    } op_t;

    // One control word. A loop step walks the slot counter; brk leaves the
    // loop early through next_t when the condition holds, and running off the
    // last slot leaves through next_f.
    typedef struct packed {
        cond_t   cond;
        logic    loop;
        logic    brk;
        logic    emit;
        kind_t   kind;
        status_t status;
        id_sel_t id_sel;
        logic    last;
        op_t     op;
        upc_t    next_t;
        upc_t    next_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t w;
        w = '{cond: COND_ALWAYS, loop: 1'b0, brk: 1'b0, emit: 1'b0, kind: KIND_START,
              status: STAT_OK, id_sel: ID_ZERO, last: 1'b0, op: OP_NONE,
              next_t: UPC_IDLE, next_f: UPC_IDLE};
        case (pc)
            UPC_START: begin
                w.cond   = COND_ZERO_PERIOD;
                w.emit   = 1'b1;
                w.status = STAT_ZERO_PERIOD;
                w.last   = 1'b1;
                w.next_f = UPC_SCAN;
            end
            UPC_SCAN: begin
                w.cond   = COND_SLOT_FREE;
                w.loop   = 1'b1;
                w.brk    = 1'b1;
                w.emit   = 1'b1;
                w.id_sel = ID_SLOT;
                w.last   = 1'b1;
                w.op     = OP_ALLOC;
                w.next_f = UPC_FULL;
            end
            UPC_FULL: begin
                w.emit   = 1'b1;
                w.status = STAT_FULL;
                w.last   = 1'b1;
            end
            UPC_DELETE: begin
                w.emit   = 1'b1;
                w.kind   = KIND_DELETE;
                w.id_sel = ID_REQ;
                w.last   = 1'b1;
                w.op     = OP_RELEASE;
            end
            UPC_TICK: begin
                w.cond   = COND_FIRE;
                w.loop   = 1'b1;
                w.emit   = 1'b1;
                w.kind   = KIND_EXPIRY;
                w.id_sel = ID_SLOT;
                w.op     = OP_ADVANCE;
                w.next_t = UPC_TICK;
                w.next_f = UPC_DONE;
            end
            UPC_DONE: begin
                w.emit   = 1'b1;
                w.kind   = KIND_DONE;
                w.last   = 1'b1;
            end
            default: begin
                w.next_t = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

    // Clamp a requested period to the stored width.
    function automatic logic [PERIOD_BITS-1:0] sat_period(logic [PERIOD_W-1:0] p);
        logic [32:0] lim;
        lim = 33'((64'd1 << PERIOD_BITS) - 64'd1);
        if (33'(p) > lim) begin
            return '1;
        end
        return PERIOD_BITS'(p);
    endfunction

endpackage

`default_nettype wire

/* sv/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// Periodic timer table
// A table of periodic timers run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser = mode; tdata = period, slot_id (24 bits)
//  m_axis    out        tuser = kind; tdata = status, timer_id (8 bits); tlast = last
//
// A start request with a zero period is refused; otherwise the slots are
// scanned for the lowest free one, and a full table is refused. A delete is
// a single step; a tick walks every slot, then gives the tick-done result.
// The sequencer visits one slot per cycle while no result stall holds it,
// through a single read port on the period and count arrays. Reset clears
// the sequencer, the active bits and the output register. A step that has a
// result to hand over waits while the output register is full and not taken.
//
`default_nettype none

`include "periodic_timer_table_macros.svh"

module periodic_timer_table
    import ptt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Request channel.
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [MODE_W-1:0]   s_axis_tuser,  // mode[1:0]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // period[15:0], slot_id[19:16]
    // Result channel.
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [KIND_W-1:0]        m_axis_tuser,  // kind[1:0]
    output logic [M_DATA_W-1:0]      m_axis_tdata,  // status[1:0], timer_id[5:2]
    output logic                     m_axis_tlast
);

    // Sequencer state.
    upc_t                   upc_reg, upc_next;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;

    // Fields of the request being worked on.
    logic [PERIOD_W-1:0]    period_reg;
    logic [ID_W-1:0]        sid_reg;

    // Timer table. Period and count are only read for active slots, so they
    // need no reset.
    logic [TIMER_SLOTS-1:0] slot_active_reg;
    logic [PERIOD_BITS-1:0] slot_period_mem  [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] slot_elapsed_mem [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] period_rd_reg;
    logic [PERIOD_BITS-1:0] elapsed_rd_reg;

    // Output register.
    logic                   m_valid_reg;
    logic [M_DATA_W-1:0]    m_data_reg;
    logic [KIND_W-1:0]      m_user_reg;
    logic                   m_last_reg;

    ucode_t                 uw;
    logic                   in_accept;
    logic                   cur_active;
    logic [PERIOD_BITS-1:0] cur_period;
    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic                   fire;
    logic                   cond_true;
    logic                   at_last_slot;
    logic                   emit_now;
    logic                   out_free;
    logic                   stall;
    logic                   step_go;
    logic                   del_in_range;
    logic [SLOT_BITS-1:0]   del_idx;
    logic [ID_W-1:0]        emit_id;
    logic [M_DATA_W-1:0]    emit_data;

    assign uw            = ucode_rom(upc_reg);
    assign s_axis_tready = (upc_reg == UPC_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // The slot counter addresses the table for scan and tick.
    assign cur_active   = slot_active_reg[idx_reg];
    assign cur_period   = period_rd_reg;
    assign elapsed_inc  = elapsed_rd_reg + PERIOD_BITS'(1);
    assign fire         = cur_active && (elapsed_inc >= cur_period);
    assign at_last_slot = (idx_reg == SLOT_BITS'(TIMER_SLOTS - 1));

    assign del_in_range = (int'(sid_reg) < TIMER_SLOTS);
    assign del_idx      = SLOT_BITS'(sid_reg);

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_ZERO_PERIOD: cond_true = (period_reg == '0);
            COND_SLOT_FREE:   cond_true = !cur_active;
            COND_FIRE:        cond_true = fire;
            default:          cond_true = 1'b0;
        endcase
    end

    // A step with a result due holds until the output register can take it.
    assign emit_now = (upc_reg != UPC_IDLE) && uw.emit && cond_true;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign stall    = emit_now && !out_free;
    assign step_go  = (upc_reg != UPC_IDLE) && !stall;

    // Next microcode address and slot counter.
    always_comb begin
        upc_next = upc_reg;
        idx_next = idx_reg;
        if (upc_reg == UPC_IDLE) begin
            if (in_accept) begin
                idx_next = '0;
                case (s_axis_tuser)
                    MODE_START:  upc_next = UPC_START;
                    MODE_DELETE: upc_next = UPC_DELETE;
                    MODE_TICK:   upc_next = UPC_TICK;
                    default:     upc_next = UPC_IDLE;
                endcase
            end
        end else if (step_go) begin
            if (uw.loop) begin
                if (cond_true && uw.brk) begin
                    upc_next = uw.next_t;
                end else if (at_last_slot) begin
                    upc_next = uw.next_f;
                end else begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                end
            end else begin
                upc_next = cond_true ? uw.next_t : uw.next_f;
            end
        end
    end

    // Result fields of the current step.
    always_comb begin
        case (uw.id_sel)
            ID_ZERO: emit_id = '0;
            ID_SLOT: emit_id = ID_W'(idx_reg);
            ID_REQ:  emit_id = sid_reg;
            default: emit_id = '0;
        endcase
        emit_data = M_DATA_W'({emit_id, uw.status});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
            idx_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            period_reg <= s_axis_tdata[0 +: PERIOD_W];
            sid_reg    <= s_axis_tdata[PERIOD_W +: ID_W];
        end
    end

    // Active bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_active_reg <= '0;
        end else if (step_go) begin
            if (uw.op == OP_ALLOC && cond_true) begin
                slot_active_reg[idx_reg] <= 1'b1;
            end else if (uw.op == OP_RELEASE && del_in_range) begin
                slot_active_reg[del_idx] <= 1'b0;
            end
        end
    end

    // Period and count arrays, one write port each.
    always_ff @(posedge aclk) begin
        if (step_go) begin
            if (uw.op == OP_ALLOC && cond_true) begin
                slot_period_mem[idx_reg]  <= sat_period(period_reg);
                slot_elapsed_mem[idx_reg] <= '0;
            end else if (uw.op == OP_ADVANCE && cur_active) begin
                slot_elapsed_mem[idx_reg] <= fire ? '0 : elapsed_inc;
            end
        end
    end

    // Read port. The arrays are read at the slot the counter moves to, so the
    // entry of the current slot sits in the read registers during its step.
    always_ff @(posedge aclk) begin
        period_rd_reg  <= slot_period_mem[idx_next];
        elapsed_rd_reg <= slot_elapsed_mem[idx_next];
    end

    // Output register: a result may wait here while the next request comes in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_now && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_now && out_free) begin
            m_data_reg <= emit_data;
            m_user_reg <= uw.kind;
            m_last_reg <= uw.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // A tick request starts its walk at the first slot.
    `PTT_ASSERT_NEXT(a_tick_starts_at_slot0,
        in_accept && s_axis_tuser == MODE_TICK,
        upc_reg == UPC_TICK && idx_reg == '0)

    // The tick-done result always closes its request.
    `PTT_ASSERT_IMPL(a_done_is_last,
        m_axis_tvalid && m_axis_tuser == KIND_DONE,
        m_axis_tlast)

    // While a result waits on a full output register, the sequencer holds its step.
    `PTT_ASSERT_NEXT(a_stall_holds_step,
        stall,
        upc_reg == $past(upc_reg) && idx_reg == $past(idx_reg))

endmodule

`default_nettype wire

/* tb/sv/periodic_timer_table_checker.sv */
// ----------------------------------------------------------------------------
// Periodic timer table checker
// Watches both channels, predicts the results of every accepted request from
// its own copy of the timer table and compares each result the block hands
// over against the oldest prediction still owed.
// ----------------------------------------------------------------------------
module periodic_timer_table_checker
    import ptt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [MODE_W-1:0]   s_axis_tuser,  // mode[1:0]
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // period[15:0], slot_id[19:16]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [KIND_W-1:0]   m_axis_tuser,  // kind[1:0]
    input  logic [M_DATA_W-1:0] m_axis_tdata,  // status[1:0], timer_id[5:2]
    input  logic                m_axis_tlast,
    output int                  fail_count,
    output int                  replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [32:0] PERIOD_MAX = (33'd1 << PERIOD_BITS) - 33'd1;

    typedef struct packed {
        kind_t          kind;
        status_t        status;
        logic [ID_W-1:0] timer_id;
        logic           last;
    } reply_t;

    reply_t                 owed_q[$];
    logic                   slot_busy  [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] slot_limit [TIMER_SLOTS];
    logic [PERIOD_BITS-1:0] slot_count [TIMER_SLOTS];
    int                     mismatches = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic owe(input kind_t kind, input status_t status,
                       input logic [ID_W-1:0] timer_id, input logic last);
        reply_t r;
        r.kind     = kind;
        r.status   = status;
        r.timer_id = timer_id;
        r.last     = last;
        owed_q = {owed_q, r};
    endtask

    // Applies one request to the table copy and queues the results it causes.
    task automatic predict_replies(input logic [MODE_W-1:0] user,
                                   input logic [S_DATA_W-1:0] data);
        logic [MODE_W-1:0]      mode;
        logic [PERIOD_W-1:0]    period;
        logic [ID_W-1:0]        sid;
        logic [PERIOD_BITS-1:0] next_count;
        bit                     placed;
        mode   = user;
        period = data[0 +: PERIOD_W];
        sid    = data[PERIOD_W +: ID_W];
        placed = 1'b0;
        case (mode)
            MODE_START: begin
                if (period == '0) begin
                    owe(KIND_START, STAT_ZERO_PERIOD, '0, 1'b1);
                end else begin
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (!placed && !slot_busy[i]) begin
                            placed        = 1'b1;
                            slot_busy[i]  = 1'b1;
                            slot_limit[i] = (33'(period) > PERIOD_MAX) ? '1 : PERIOD_BITS'(period);
                            slot_count[i] = '0;
                            owe(KIND_START, STAT_OK, ID_W'(i), 1'b1);
                        end
                    end
                    if (!placed) begin
                        owe(KIND_START, STAT_FULL, '0, 1'b1);
                    end
                end
            end
            MODE_DELETE: begin
                if (int'(sid) < TIMER_SLOTS) begin
                    slot_busy[sid] = 1'b0;
                end
                owe(KIND_DELETE, STAT_OK, sid, 1'b1);
            end
            MODE_TICK: begin
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        next_count = slot_count[i] + 1'b1;
                        if (next_count >= slot_limit[i]) begin
                            slot_count[i] = '0;
                            owe(KIND_EXPIRY, STAT_OK, ID_W'(i), 1'b0);
                        end else begin
                            slot_count[i] = next_count;
                        end
                    end
                end
                owe(KIND_DONE, STAT_OK, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                slot_busy[i] = 1'b0;
            end
            owed_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d status %0d id %0d last %0b",
                                              m_axis_tuser, m_axis_tdata[1:0],
                                              m_axis_tdata[5:2], m_axis_tlast));
                end else begin
                    want = owed_q.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[1:0] !== want.status ||
                        m_axis_tdata[5:2] !== want.timer_id || m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %0d status %0d id %0d last %0b, want %0d %0d %0d %0b",
                            m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[5:2],
                            m_axis_tlast, want.kind, want.status, want.timer_id, want.last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_replies(s_axis_tuser, s_axis_tdata);
            end
        end
        fail_count   <= mismatches;
        replies_owed <= owed_q.size();
    end

endmodule

/* tb/sv/periodic_timer_table_test.sv */
// ----------------------------------------------------------------------------
// Periodic timer table test
// Drives start, delete and tick requests into the timer table with random
// gaps and result back-pressure; a checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module periodic_timer_table_test;
    import ptt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;

    // The mode field has one code that the block ignores without a result.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Random requests that the block acts on; ignored ones come on top.
    localparam int RANDOM_REQUESTS = 330;

    // The receiver stops taking results for this long once, after this many
    // results, so that the output and then the request channel back up.
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    // Settle time after the last result before the verdict, so that late extra
    // results are still seen.
    localparam int SETTLE_CYCLES = 2 * TIMER_SLOTS + 8;

    // Longest stretch without any handshake before the run is declared hung.
    // The receiver hold-off is the longest legal one.
    localparam int IDLE_LIMIT = 2000;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [MODE_W-1:0]   s_axis_tuser  = '0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [KIND_W-1:0]   m_axis_tuser;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    int fail_count;
    int replies_owed;
    int idle_cycles = 0;

    // When set, the sender offers requests back to back with no gaps.
    bit sender_eager = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    periodic_timer_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    periodic_timer_table_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .replies_owed  (replies_owed)
    );

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted. Must be
    // called right after a rising edge. With no gap, tvalid simply stays high
    // from the previous request, so it is never lowered and raised in one step.
    task automatic offer_request(input logic [MODE_W-1:0] mode,
                                 input logic [PERIOD_W-1:0] period,
                                 input logic [ID_W-1:0] sid);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= S_DATA_W'({sid, period});
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic await_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_owed != 0);
    endtask

    // Result side: a random stall before each result, with stretches where
    // tready just stays high, and one long hold-off while the sender keeps going.
    initial begin : result_sink
        int gap;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken % 32 == 0) begin
                eager = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = eager ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            taken++;
        end
    end

    initial begin : request_source
        int                  sent;
        int                  pick;
        int                  span;
        bit                  filling;
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     sid;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. A tick on an empty table gives only the tick-done
        // result, and deleting a slot that was never started is harmless.
        offer_request(MODE_TICK, 16'h0000, 4'h0);
        offer_request(MODE_DELETE, 16'h0000, 4'h0);
        // A zero period is refused and takes no slot.
        offer_request(MODE_START, 16'h0000, 4'hF);
        // Slots 0, 1 and 2 with the shortest, the longest and a short period.
        offer_request(MODE_START, 16'h0001, 4'h0);
        offer_request(MODE_START, 16'hFFFF, 4'h0);
        offer_request(MODE_START, 16'h0002, 4'h0);
        // First tick fires slot 0 alone, the second fires slots 0 and 2.
        offer_request(MODE_TICK, 16'h0000, 4'h0);
        offer_request(MODE_TICK, 16'h0000, 4'h0);
        // The unused mode code is dropped without any result.
        offer_request(MODE_UNUSED, 16'hFFFF, 4'hF);
        // Fill the rest of the table, then one more start finds it full.
        for (int n = 3; n < TIMER_SLOTS; n++) begin
            offer_request(MODE_START, PERIOD_W'(n), ID_W'(n));
        end
        offer_request(MODE_START, 16'h0007, 4'h0);
        // Freeing a middle slot makes it the lowest free one again.
        offer_request(MODE_DELETE, 16'h0000, 4'h5);
        offer_request(MODE_START, 16'h0003, 4'h0);
        offer_request(MODE_DELETE, 16'h0000, 4'hF);
        offer_request(MODE_TICK, 16'h0000, 4'h0);
        await_replies();

        // Random part. Each phase is picked at random as filling or emptying the
        // table, so that both the full table and the empty one can come up.
        // Periods are mostly short so that ticks fire many slots at once.
        sent    = 0;
        filling = 1'b1;
        while (sent < RANDOM_REQUESTS) begin
            if (sent % 40 == 0) begin
                filling      = $urandom_range(0, 1);
                sender_eager = ($urandom_range(0, 3) == 0);
            end
            // Halfway through, let the block drain completely once.
            if (sent == RANDOM_REQUESTS / 2) begin
                await_replies();
            end
            pick   = $urandom_range(0, 99);
            span   = $urandom_range(0, 19);
            sid    = ID_W'($urandom_range(0, (1 << ID_W) - 1));
            period = PERIOD_W'($urandom);
            if (pick < 3) begin
                mode = MODE_UNUSED;
            end else if (pick < (filling ? 55 : 20)) begin
                mode = MODE_START;
                if (span == 0) begin
                    period = '0;
                end else if (span == 1) begin
                    period = '1;
                end else if (span > 2) begin
                    period = PERIOD_W'($urandom_range(1, 6));
                end
            end else if (pick < (filling ? 70 : 60)) begin
                mode = MODE_DELETE;
            end else begin
                mode = MODE_TICK;
            end
            offer_request(mode, period, sid);
            if (mode != MODE_UNUSED) begin
                sent++;
            end
        end

        // Wait for the last results, then a little longer for strays.
        await_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && replies_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/ptt_pkg.sv
sv/periodic_timer_table.sv
tb/sv/periodic_timer_table_checker.sv
tb/sv/periodic_timer_table_test.sv
